/* rtl/dtq_pkg.sv */
// shared types and constants for the deadline timer queue
package dtq_pkg;

    // fixed field widths
    localparam int ID_W    = 4;
    localparam int NUM_IDS = 16;
    localparam int DATA_W  = 32;

    // request opcodes
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // result kinds
    typedef enum logic [2:0] {
        KIND_CREATED     = 3'd0,
        KIND_FULL        = 3'd1,
        KIND_ARMED       = 3'd2,
        KIND_CANCELLED   = 3'd3,
        KIND_CANCEL_FAIL = 3'd4,
        KIND_EXPIRED     = 3'd5,
        KIND_NONE_DUE    = 3'd6
    } kind_t;

    // per-timer status
    typedef enum logic [1:0] {
        TS_IDLE  = 2'd0,
        TS_ARMED = 2'd1,
        TS_FIRED = 2'd2
    } timer_status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEEK_SLOT,
        S_SEEK_ID,
        S_SEEK_DUE,
        S_FIRE,
        S_REFRESH
    } seq_state_t;

    // request transfer
    typedef struct packed {
        logic [1:0]        opcode;
        logic [ID_W-1:0]   timer_id;
        logic [DATA_W-1:0] deadline;
        logic [DATA_W-1:0] now;
    } req_t;

    // result transfer
    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   timer_id_res;
        logic [DATA_W-1:0] next_deadline;
        logic              last;
    } rsp_t;

    // order list update command
    typedef struct packed {
        logic            insert;
        logic            remove;
        logic [ID_W-1:0] id;
    } list_cmd_t;

    // timer table update command
    typedef struct packed {
        logic            wr_deadline;
        logic            wr_status;
        logic [ID_W-1:0] id;
        timer_status_t   status;
    } tbl_cmd_t;

endpackage

/* rtl/dtq_order_list.sv */
// deadline-ordered list of timer ids; insert and remove shift all slots in parallel
module dtq_order_list #(
    parameter int NUM_TIMERS = 16,
    parameter int CNT_W      = 5,
    parameter int IDX_W      = 4
) (
    input  logic                       clk,
    input  dtq_pkg::list_cmd_t         cmd,
    input  logic [CNT_W-1:0]           pos,
    input  logic [IDX_W-1:0]           rd_idx,
    output logic [dtq_pkg::ID_W-1:0]   rd_id
);

    logic [dtq_pkg::ID_W-1:0] list_reg  [NUM_TIMERS];
    logic [dtq_pkg::ID_W-1:0] list_next [NUM_TIMERS];

    // each slot looks only at its neighbors; slot 0 takes the inserted id from below
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_slot
        logic [dtq_pkg::ID_W-1:0] below;
        logic [dtq_pkg::ID_W-1:0] above;

        if (g == 0) begin : g_first
            assign below = cmd.id;
        end
        else begin : g_mid
            assign below = list_reg[g-1];
        end

        if (g == NUM_TIMERS - 1) begin : g_top
            assign above = list_reg[g];
        end
        else begin : g_low
            assign above = list_reg[g+1];
        end

        // insert shifts up from pos, remove shifts down onto pos
        assign list_next[g] =
            (cmd.insert && (CNT_W'(g) >  pos)) ? below  :
            (cmd.insert && (CNT_W'(g) == pos)) ? cmd.id :
            (cmd.remove && (CNT_W'(g) >= pos)) ? above  :
                                                 list_reg[g];
    end

    // list storage
    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
    end

    assign rd_id = list_reg[rd_idx];

endmodule

/* rtl/dtq_timer_table.sv */
// per-timer deadline and status storage
module dtq_timer_table #(
    parameter int DL_W = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dtq_pkg::tbl_cmd_t             cmd,
    input  logic [DL_W-1:0]               wr_deadline,
    input  logic [dtq_pkg::ID_W-1:0]      rd_id,
    output logic [DL_W-1:0]               rd_deadline,
    input  logic [dtq_pkg::ID_W-1:0]      st_id,
    output dtq_pkg::timer_status_t        rd_status
);

    logic [DL_W-1:0]        deadline_reg [dtq_pkg::NUM_IDS];
    dtq_pkg::timer_status_t status_reg   [dtq_pkg::NUM_IDS];

    // deadlines, only read while the timer is armed
    always_ff @(posedge clk)
    begin
        if (cmd.wr_deadline)
        begin
            deadline_reg[cmd.id] <= wr_deadline;
        end
    end

    // status, all idle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dtq_pkg::NUM_IDS; i++)
            begin
                status_reg[i] <= dtq_pkg::TS_IDLE;
            end
        end
        else if (cmd.wr_status)
        begin
            status_reg[cmd.id] <= cmd.status;
        end
    end

    assign rd_deadline = deadline_reg[rd_id];
    assign rd_status   = status_reg[st_id];

endmodule

/* rtl/dtq_ctrl.sv */
// request sequencer with the shared deadline comparator
module dtq_ctrl #(
    parameter int NUM_TIMERS = 16,
    parameter int CNT_W      = 5,
    parameter int IDX_W      = 4,
    parameter int DL_W       = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  dtq_pkg::req_t               req,
    output logic                        busy,
    output dtq_pkg::list_cmd_t          list_cmd,
    output logic [CNT_W-1:0]            list_pos,
    output logic [IDX_W-1:0]            list_rd_idx,
    input  logic [dtq_pkg::ID_W-1:0]    list_rd_id,
    output dtq_pkg::tbl_cmd_t           tbl_cmd,
    output logic [DL_W-1:0]             tbl_deadline,
    input  logic [DL_W-1:0]             tbl_rd_deadline,
    output logic [dtq_pkg::ID_W-1:0]    tbl_st_id,
    input  dtq_pkg::timer_status_t      tbl_rd_status,
    output logic                        rsp_load,
    output dtq_pkg::rsp_t               rsp
);

    localparam logic [DL_W-1:0]  DL_EMPTY = '1;
    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(NUM_TIMERS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    dtq_pkg::seq_state_t      state_reg, state_next;
    logic [1:0]               op_reg, op_next;
    logic [dtq_pkg::ID_W-1:0] id_reg, id_next;
    logic [DL_W-1:0]          dl_reg, dl_next;
    logic [DL_W-1:0]          now_reg, now_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [DL_W-1:0]          earliest_reg, earliest_next;

    logic            in_list;
    logic            armed;
    logic            full;
    logic            id_hit;
    logic            head_sel;
    logic [DL_W-1:0] cmp_a;
    logic [DL_W-1:0] cmp_b;
    logic            cmp_lt;
    logic            due;
    logic [DL_W-1:0] head_dl;
    logic [DL_W-1:0] stop_dl;

    // status flags
    assign busy     = (state_reg != dtq_pkg::S_IDLE);
    assign in_list  = (pos_reg < count_reg);
    assign armed    = (tbl_rd_status == dtq_pkg::TS_ARMED);
    assign full     = (count_reg >= CNT_CAP);
    assign id_hit   = in_list && (list_rd_id == id_reg);
    assign head_sel = (state_reg inside {dtq_pkg::S_REFRESH, dtq_pkg::S_FIRE});

    // list addressing: head in refresh and fire, walk position otherwise
    assign list_pos    = head_sel ? '0 : pos_reg;
    assign list_rd_idx = head_sel ? '0 : pos_reg[IDX_W-1:0];
    assign tbl_st_id   = id_reg;
    assign tbl_deadline = dl_reg;

    // shared comparator: slot search tests entry < new deadline,
    // due search tests now < entry (entry not yet due)
    assign cmp_a  = (state_reg == dtq_pkg::S_SEEK_DUE) ? now_reg : tbl_rd_deadline;
    assign cmp_b  = (state_reg == dtq_pkg::S_SEEK_DUE) ? tbl_rd_deadline : dl_reg;
    assign cmp_lt = (cmp_a < cmp_b);
    assign due    = in_list && !cmp_lt;

    assign head_dl = (count_reg == '0) ? DL_EMPTY : tbl_rd_deadline;
    assign stop_dl = in_list ? tbl_rd_deadline : DL_EMPTY;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = dtq_pkg::S_DISPATCH;
                end
            end
            dtq_pkg::S_DISPATCH:
            begin
                case (op_reg)
                    dtq_pkg::OP_CREATE:
                        state_next = (armed || full) ? dtq_pkg::S_IDLE : dtq_pkg::S_SEEK_SLOT;
                    dtq_pkg::OP_CANCEL:
                        state_next = armed ? dtq_pkg::S_SEEK_ID : dtq_pkg::S_IDLE;
                    dtq_pkg::OP_TICK:
                        state_next = dtq_pkg::S_SEEK_DUE;
                    default:
                        state_next = dtq_pkg::S_IDLE;
                endcase
            end
            dtq_pkg::S_SEEK_SLOT:
            begin
                if (!(in_list && cmp_lt))
                begin
                    state_next = dtq_pkg::S_REFRESH;
                end
            end
            dtq_pkg::S_SEEK_ID:
            begin
                if (id_hit || !in_list)
                begin
                    state_next = dtq_pkg::S_REFRESH;
                end
            end
            dtq_pkg::S_SEEK_DUE:
            begin
                if (!due)
                begin
                    state_next = (pos_reg == '0) ? dtq_pkg::S_IDLE : dtq_pkg::S_FIRE;
                end
            end
            dtq_pkg::S_FIRE:
            begin
                if (pos_reg == CNT_ONE)
                begin
                    state_next = dtq_pkg::S_IDLE;
                end
            end
            dtq_pkg::S_REFRESH:
            begin
                state_next = dtq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dtq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath updates, storage commands and results
    always_comb
    begin
        op_next       = op_reg;
        id_next       = id_reg;
        dl_next       = dl_reg;
        now_next      = now_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        earliest_next = earliest_reg;

        list_cmd        = '0;
        tbl_cmd         = '0;
        tbl_cmd.id      = id_reg;
        tbl_cmd.status  = dtq_pkg::TS_IDLE;

        rsp_load          = 1'b0;
        rsp.kind          = dtq_pkg::KIND_CREATED;
        rsp.timer_id_res  = id_reg;
        rsp.next_deadline = dtq_pkg::DATA_W'(earliest_reg);
        rsp.last          = 1'b1;

        case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next  = req.opcode;
                    id_next  = req.timer_id;
                    dl_next  = req.deadline[DL_W-1:0];
                    now_next = req.now[DL_W-1:0];
                end
            end
            dtq_pkg::S_DISPATCH:
            begin
                pos_next = '0;
                case (op_reg)
                    dtq_pkg::OP_CREATE:
                    begin
                        if (armed)
                        begin
                            rsp_load = 1'b1;
                            rsp.kind = dtq_pkg::KIND_ARMED;
                        end
                        else if (full)
                        begin
                            rsp_load = 1'b1;
                            rsp.kind = dtq_pkg::KIND_FULL;
                        end
                    end
                    dtq_pkg::OP_CANCEL:
                    begin
                        if (!armed)
                        begin
                            rsp_load = 1'b1;
                            rsp.kind = dtq_pkg::KIND_CANCEL_FAIL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            dtq_pkg::S_SEEK_SLOT:
            begin
                // walk past entries that expire strictly earlier
                if (in_list && cmp_lt)
                begin
                    pos_next = pos_reg + CNT_ONE;
                end
                else
                begin
                    list_cmd.insert     = 1'b1;
                    list_cmd.id         = id_reg;
                    tbl_cmd.wr_deadline = 1'b1;
                    tbl_cmd.wr_status   = 1'b1;
                    tbl_cmd.status      = dtq_pkg::TS_ARMED;
                    count_next          = count_reg + CNT_ONE;
                end
            end
            dtq_pkg::S_SEEK_ID:
            begin
                if (id_hit)
                begin
                    list_cmd.remove   = 1'b1;
                    tbl_cmd.wr_status = 1'b1;
                    tbl_cmd.status    = dtq_pkg::TS_IDLE;
                    count_next        = count_reg - CNT_ONE;
                end
                else if (in_list)
                begin
                    pos_next = pos_reg + CNT_ONE;
                end
            end
            dtq_pkg::S_REFRESH:
            begin
                earliest_next     = head_dl;
                rsp_load          = 1'b1;
                rsp.kind          = (op_reg == dtq_pkg::OP_CREATE) ?
                                    dtq_pkg::KIND_CREATED : dtq_pkg::KIND_CANCELLED;
                rsp.next_deadline = dtq_pkg::DATA_W'(head_dl);
            end
            dtq_pkg::S_SEEK_DUE:
            begin
                // count due entries; the first one not due is the new head
                if (due)
                begin
                    pos_next = pos_reg + CNT_ONE;
                end
                else
                begin
                    earliest_next = stop_dl;
                    if (pos_reg == '0)
                    begin
                        rsp_load          = 1'b1;
                        rsp.kind          = dtq_pkg::KIND_NONE_DUE;
                        rsp.timer_id_res  = '0;
                        rsp.next_deadline = dtq_pkg::DATA_W'(stop_dl);
                    end
                end
            end
            dtq_pkg::S_FIRE:
            begin
                // pop the head, one expired timer per cycle
                rsp_load          = 1'b1;
                rsp.kind          = dtq_pkg::KIND_EXPIRED;
                rsp.timer_id_res  = list_rd_id;
                rsp.last          = (pos_reg == CNT_ONE);
                tbl_cmd.wr_status = 1'b1;
                tbl_cmd.id        = list_rd_id;
                tbl_cmd.status    = dtq_pkg::TS_FIRED;
                list_cmd.remove   = 1'b1;
                count_next        = count_reg - CNT_ONE;
                pos_next          = pos_reg - CNT_ONE;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dtq_pkg::S_IDLE;
            count_reg    <= '0;
            pos_reg      <= '0;
            earliest_reg <= DL_EMPTY;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            earliest_reg <= earliest_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        id_reg  <= id_next;
        dl_reg  <= dl_next;
        now_reg <= now_next;
    end

endmodule

/* rtl/deadline_timer_queue.sv */
// top level of the deadline-ordered one-shot timer queue
//
// Usage: drive req and raise start; the request transfers at a rising edge
// with start high and busy low. Opcodes: create, cancel, tick; opcode 3 is
// dropped with no result. Results come out on result, each valid for exactly
// one cycle with result_strobe high; result.last marks the final one of a
// request. The receiver cannot stall the block.
// One sequencer walks the order list one entry per cycle through a single
// deadline comparator:
//   create: walks past the entries ahead of the slot, then inserts the timer
//   cancel: walks to the list position of the timer, then removes it
//   tick:   one none-due result when nothing is due, else walks the due
//           timers, then gives one expired result per cycle until every
//           due timer has fired
// Rejected creates and failed cancels are answered from the dispatch state.
// busy stays high from the transfer until the last result is loaded.
// Reset clears the queue, marks every timer idle and sets the reported next
// deadline to all ones; no clearing pass is needed.
module deadline_timer_queue #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dtq_pkg::req_t req,
    output logic          busy,
    output logic          result_strobe,
    output dtq_pkg::rsp_t result
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam int DL_W  = (TIME_BITS < dtq_pkg::DATA_W) ? TIME_BITS : dtq_pkg::DATA_W;

    dtq_pkg::list_cmd_t       list_cmd;
    logic [CNT_W-1:0]         list_pos;
    logic [IDX_W-1:0]         list_rd_idx;
    logic [dtq_pkg::ID_W-1:0] list_rd_id;
    dtq_pkg::tbl_cmd_t        tbl_cmd;
    logic [DL_W-1:0]          tbl_deadline;
    logic [DL_W-1:0]          tbl_rd_deadline;
    logic [dtq_pkg::ID_W-1:0] tbl_st_id;
    dtq_pkg::timer_status_t   tbl_rd_status;
    logic                     rsp_load;
    dtq_pkg::rsp_t            rsp;

    logic          strobe_reg;
    dtq_pkg::rsp_t result_reg;

    dtq_ctrl #(
        .NUM_TIMERS (NUM_TIMERS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W),
        .DL_W       (DL_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .req             (req),
        .busy            (busy),
        .list_cmd        (list_cmd),
        .list_pos        (list_pos),
        .list_rd_idx     (list_rd_idx),
        .list_rd_id      (list_rd_id),
        .tbl_cmd         (tbl_cmd),
        .tbl_deadline    (tbl_deadline),
        .tbl_rd_deadline (tbl_rd_deadline),
        .tbl_st_id       (tbl_st_id),
        .tbl_rd_status   (tbl_rd_status),
        .rsp_load        (rsp_load),
        .rsp             (rsp)
    );

    dtq_order_list #(
        .NUM_TIMERS (NUM_TIMERS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_order_list (
        .clk    (clk),
        .cmd    (list_cmd),
        .pos    (list_pos),
        .rd_idx (list_rd_idx),
        .rd_id  (list_rd_id)
    );

    dtq_timer_table #(
        .DL_W (DL_W)
    ) u_timer_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (tbl_cmd),
        .wr_deadline (tbl_deadline),
        .rd_id       (list_rd_id),
        .rd_deadline (tbl_rd_deadline),
        .st_id       (tbl_st_id),
        .rd_status   (tbl_rd_status)
    );

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= rsp_load;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            result_reg <= rsp;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // an accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    // a result that is not the last leaves the block still working
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |-> busy)
        else $error("non-final result while idle");

    // expired results of one tick come in consecutive cycles
    a_fire_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last && result.kind == dtq_pkg::KIND_EXPIRED)
        |=> result_strobe)
        else $error("gap inside an expiry burst");

endmodule
